// File: rtl/sfr_pkg.sv
// Shared types, codes and reset values for the serial frame receiver.
package sfr_pkg;

  // Widths of the stream and register fields.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 8;

  // Receiver phases.
  localparam logic [PhaseW-1:0] PH_HUNT   = 2'd0;
  localparam logic [PhaseW-1:0] PH_SECOND = 2'd1;
  localparam logic [PhaseW-1:0] PH_LENGTH = 2'd2;
  localparam logic [PhaseW-1:0] PH_BODY   = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_HEADER = 2'd1;
  localparam logic [StatusW-1:0] ST_LENGTH = 2'd2;
  localparam logic [StatusW-1:0] ST_SUM    = 2'd3;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_SECOND = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH    = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD   = 8'd3;

  // Register reset values.
  localparam logic [ByteW-1:0] RST_HEADER_FIRST  = 8'd170;
  localparam logic [ByteW-1:0] RST_HEADER_SECOND = 8'd85;
  localparam logic [ByteW-1:0] RST_MIN_LENGTH    = 8'd4;
  localparam logic [ByteW-1:0] RST_MAX_PAYLOAD   = 8'd32;

  // Shortest length byte that can hold a length and a checksum.
  localparam logic [ByteW-1:0] MIN_LEGAL_LENGTH = 8'd2;

  // Register file contents as seen by the deframer.
  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] min_frame_length;
    logic [ByteW-1:0] max_payload_length;
  } sfr_cfg_t;

endpackage

// File: rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver: register file and deframer.
//
//   Channel | Direction | Handshake           | Contents
//   in_     | slave     | in_tvalid/in_tready | tdata[7:0] rx_byte
//   out_    | master    | out_tvalid/tready   | tdata frame_byte, byte_position,
//           |           |                     | frame_length; tlast; tuser status
//   cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte is accepted per cycle while in_tready is high; each result passes the
// input register, then the result register. Matching header bytes and legal
// length bytes give no beat. Reset (rst_n low, synchronous) returns to hunt and
// reloads register defaults. A stall on out_tready holds the result and the
// input register; in_tready drops only when both are full.
module serial_frame_receiver
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Received bytes.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ByteW-1:0]   in_tdata,   // [7:0] rx_byte
  // Frame bytes and status.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [3*ByteW-1:0] out_tdata,  // [7:0] frame_byte, [15:8] byte_position,
                                         // [23:16] frame_length
  output logic               out_tlast,  // is_last
  output logic [StatusW-1:0] out_tuser,  // [1:0] status
  // Register writes.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  sfr_cfg_t cfg;

  sfr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  sfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/sfr_regs.sv
// Configuration register file of the serial frame receiver.
module sfr_regs
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data,
  output sfr_cfg_t           cfg_o
);

  sfr_cfg_t cfg_r;
  sfr_cfg_t cfg_nxt;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  cfg_nxt.header_first       = cfg_data;
        REG_HEADER_SECOND: cfg_nxt.header_second      = cfg_data;
        REG_MIN_LENGTH:    cfg_nxt.min_frame_length   = cfg_data;
        REG_MAX_PAYLOAD:   cfg_nxt.max_payload_length = cfg_data;
        default:           cfg_nxt                    = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first       <= RST_HEADER_FIRST;
      cfg_r.header_second      <= RST_HEADER_SECOND;
      cfg_r.min_frame_length   <= RST_MIN_LENGTH;
      cfg_r.max_payload_length <= RST_MAX_PAYLOAD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/sfr_core.sv
// Deframer datapath: input register, frame state update and result register.
module sfr_core
  import sfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_cfg_t           cfg_i,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ByteW-1:0]   in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [3*ByteW-1:0] out_tdata,
  output logic               out_tlast,
  output logic [StatusW-1:0] out_tuser
);

  // Input register.
  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] byte_r, byte_nxt;

  // Frame state.
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [ByteW-1:0]  sum_r, sum_nxt;
  logic [ByteW-1:0]  left_r, left_nxt;
  logic [ByteW-1:0]  len_r, len_nxt;
  logic [ByteW-1:0]  pos_r, pos_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic [ByteW-1:0]   res_byte_r, res_byte_nxt;
  logic [ByteW-1:0]   res_pos_r, res_pos_nxt;
  logic [ByteW-1:0]   res_len_r, res_len_nxt;
  logic               res_last_r, res_last_nxt;
  logic [StatusW-1:0] res_st_r, res_st_nxt;

  // Result of the current byte before registering.
  logic               res_valid;
  logic [ByteW-1:0]   res_pos;
  logic [ByteW-1:0]   res_len;
  logic               res_last;
  logic [StatusW-1:0] res_st;

  logic           out_free;
  logic           proc;
  logic [ByteW:0] upper;
  logic           len_bad;
  logic [ByteW-1:0] pos_inc;
  logic [ByteW-1:0] left_dec;

  // The held byte is processed once the result register can take a beat.
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign upper    = {1'b0, cfg_i.min_frame_length} + {1'b0, cfg_i.max_payload_length};
  assign len_bad  = (byte_r < MIN_LEGAL_LENGTH) || (byte_r < cfg_i.min_frame_length) ||
                    ({1'b0, byte_r} > upper);
  assign pos_inc  = pos_r + 8'd1;
  assign left_dec = left_r - 8'd1;

  // Input register load.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    byte_nxt     = byte_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
      if (in_tvalid) begin
        byte_nxt = in_tdata;
      end
    end
  end

  // Frame state machine, one byte per step.
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    left_nxt  = left_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    res_valid = 1'b0;
    res_pos   = '0;
    res_len   = '0;
    res_last  = 1'b0;
    res_st    = ST_OK;
    if (proc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_r == cfg_i.header_first) begin
            phase_nxt = PH_SECOND;
          end
        end
        PH_SECOND: begin
          if (byte_r == cfg_i.header_second) begin
            phase_nxt = PH_LENGTH;
          end else begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            res_last  = 1'b1;
            res_st    = ST_HEADER;
          end
        end
        PH_LENGTH: begin
          if (len_bad) begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            res_len   = byte_r;
            res_last  = 1'b1;
            res_st    = ST_LENGTH;
          end else begin
            len_nxt   = byte_r;
            sum_nxt   = byte_r;
            left_nxt  = byte_r - 8'd1;
            pos_nxt   = '0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          pos_nxt   = pos_inc;
          left_nxt  = left_dec;
          res_valid = 1'b1;
          res_pos   = pos_inc;
          res_len   = len_r;
          if (left_dec == '0) begin
            // Checksum byte closes the frame.
            phase_nxt = PH_HUNT;
            res_last  = 1'b1;
            res_st    = (sum_r == byte_r) ? ST_OK : ST_SUM;
          end else begin
            sum_nxt = sum_r + byte_r;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Result register load.
  always_comb begin
    out_valid_nxt = out_valid_r;
    res_byte_nxt  = res_byte_r;
    res_pos_nxt   = res_pos_r;
    res_len_nxt   = res_len_r;
    res_last_nxt  = res_last_r;
    res_st_nxt    = res_st_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        res_byte_nxt = byte_r;
        res_pos_nxt  = res_pos;
        res_len_nxt  = res_len;
        res_last_nxt = res_last;
        res_st_nxt   = res_st;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HUNT;
      sum_r       <= '0;
      left_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      left_r      <= left_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    res_byte_r <= res_byte_nxt;
    res_pos_r  <= res_pos_nxt;
    res_len_r  <= res_len_nxt;
    res_last_r <= res_last_nxt;
    res_st_r   <= res_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_len_r, res_pos_r, res_byte_r};
  assign out_tlast  = res_last_r;
  assign out_tuser  = res_st_r;

endmodule

// File: rtl/sfr_checker.sv
// Port-level checks on the serial frame receiver result stream.
module sfr_checker
  import sfr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [3*ByteW-1:0] out_tdata,
  input logic               out_tlast,
  input logic [StatusW-1:0] out_tuser
);

  // No result beat is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat offered after reset");

  // A stalled result beat holds its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result beat changed");

  // Every error status closes the frame.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast)
    else $error("error beat without tlast");

  // Header and length errors carry no byte position.
  a_error_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_HEADER || out_tuser == ST_LENGTH) |->
      out_tdata[2*ByteW-1:ByteW] == '0)
    else $error("error beat with a byte position");

  // Body beats sit at a nonzero position within the frame length.
  a_body_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_OK || out_tuser == ST_SUM) |->
      out_tdata[2*ByteW-1:ByteW] != '0 &&
      out_tdata[2*ByteW-1:ByteW] < out_tdata[3*ByteW-1:2*ByteW])
    else $error("body beat position out of frame");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

// File: dv/serial_frame_receiver_test.sv
// Self-checking testbench for the serial frame receiver: framing, length bounds and checksum.
module serial_frame_receiver_test
  import sfr_pkg::*;
;

  // One frame byte or error report as it leaves the block.
  typedef struct packed {
    logic [ByteW-1:0]   frame_byte;
    logic [ByteW-1:0]   byte_position;
    logic [ByteW-1:0]   frame_length;
    logic               is_last;
    logic [StatusW-1:0] status;
  } frame_result_t;

  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BYTES  = 1650;
  localparam int PRINT_LIMIT   = 30;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [ByteW-1:0]   in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [3*ByteW-1:0] out_tdata;
  logic               out_tlast;
  logic [StatusW-1:0] out_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ByteW-1:0]   cfg_data;

  serial_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Mirror of the register file and of the deframer state.
  sfr_cfg_t         reg_model;
  logic [PhaseW-1:0] rx_phase;
  logic [ByteW-1:0] rx_sum;
  logic [ByteW-1:0] rx_left;
  logic [ByteW-1:0] rx_length;
  logic [ByteW-1:0] rx_position;

  frame_result_t pending_results[$];

  int error_count    = 0;
  int results_seen   = 0;
  int bytes_sent     = 0;
  int bytes_dropped  = 0;
  int frames_sent    = 0;
  int settings_used  = 0;
  int header_errors  = 0;
  int length_errors  = 0;
  int sum_errors     = 0;

  // Source burst control and sink stall control.
  int          burst_left    = 0;
  bit          steady_source = 1'b0;
  int          sink_hold     = 0;
  logic [31:0] sink_cycle    = '0;

  frame_result_t got_result;
  frame_result_t want_result;

  always #5 clk = ~clk;

  // One line per mismatch; printing stops after a while but counting does not.
  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH %s: got %0d, want %0d (result %0d)", what, got_v, want_v, results_seen);
  endtask

  function automatic void reset_model();
    reg_model.header_first       = RST_HEADER_FIRST;
    reg_model.header_second      = RST_HEADER_SECOND;
    reg_model.min_frame_length   = RST_MIN_LENGTH;
    reg_model.max_payload_length = RST_MAX_PAYLOAD;
    rx_phase    = PH_HUNT;
    rx_sum      = '0;
    rx_left     = '0;
    rx_length   = '0;
    rx_position = '0;
  endfunction

  function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
                                         input logic [ByteW-1:0] val);
    case (idx)
      REG_HEADER_FIRST:  reg_model.header_first       = val;
      REG_HEADER_SECOND: reg_model.header_second      = val;
      REG_MIN_LENGTH:    reg_model.min_frame_length   = val;
      REG_MAX_PAYLOAD:   reg_model.max_payload_length = val;
      default: ;
    endcase
  endfunction

  function automatic void queue_result(input logic [ByteW-1:0] b, input logic [ByteW-1:0] pos,
                                       input logic [ByteW-1:0] len, input logic last,
                                       input logic [StatusW-1:0] st);
    frame_result_t r;
    r.frame_byte    = b;
    r.byte_position = pos;
    r.frame_length  = len;
    r.is_last       = last;
    r.status        = st;
    pending_results = {pending_results, r};
  endfunction

  // Advance the deframer mirror by one accepted byte.
  function automatic void deframe_predict(input logic [ByteW-1:0] b);
    logic [ByteW:0] upper;
    upper = {1'b0, reg_model.min_frame_length} + {1'b0, reg_model.max_payload_length};
    case (rx_phase)
      PH_HUNT: begin
        if (b == reg_model.header_first) rx_phase = PH_SECOND;
        else bytes_dropped++;
      end
      PH_SECOND: begin
        if (b == reg_model.header_second) begin
          rx_phase = PH_LENGTH;
        end else begin
          rx_phase = PH_HUNT;
          header_errors++;
          queue_result(b, '0, '0, 1'b1, ST_HEADER);
        end
      end
      PH_LENGTH: begin
        if (b < MIN_LEGAL_LENGTH || b < reg_model.min_frame_length || {1'b0, b} > upper) begin
          rx_phase = PH_HUNT;
          length_errors++;
          queue_result(b, '0, b, 1'b1, ST_LENGTH);
        end else begin
          rx_length   = b;
          rx_sum      = b;
          rx_left     = b - 8'd1;
          rx_position = '0;
          rx_phase    = PH_BODY;
        end
      end
      default: begin
        rx_position = rx_position + 8'd1;
        rx_left     = rx_left - 8'd1;
        if (rx_left == '0) begin
          rx_phase = PH_HUNT;
          if (rx_sum != b) sum_errors++;
          queue_result(b, rx_position, rx_length, 1'b1, (rx_sum == b) ? ST_OK : ST_SUM);
        end else begin
          rx_sum = rx_sum + b;
          queue_result(b, rx_position, rx_length, 1'b0, ST_OK);
        end
      end
    endcase
  endfunction

  // Offer one byte at the falling edge and hold it until the block takes the beat.
  task automatic send_byte(input logic [ByteW-1:0] b);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    deframe_predict(b);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
    end
  endtask

  // Bytes go out in bursts of random length; gaps between them are random unless steady.
  task automatic send_item(input logic [ByteW-1:0] b);
    if (burst_left == 0) begin
      if (!steady_source) idle_cycles(int'($urandom_range(0, 6)));
      burst_left = int'($urandom_range(1, 24));
    end
    burst_left--;
    send_byte(b);
  endtask

  // Stop offering bytes and wait, up to DRAIN_LIMIT, until every predicted result is seen.
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch("results still pending", pending_results.size(), 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only once the block has gone idle.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= 8'($urandom);
    cfg_data  <= 8'($urandom);
  endtask

  task automatic write_all_registers(input logic [ByteW-1:0] hf, input logic [ByteW-1:0] hs,
                                     input logic [ByteW-1:0] min_len,
                                     input logic [ByteW-1:0] max_pay);
    write_register(REG_HEADER_FIRST, hf);
    write_register(REG_HEADER_SECOND, hs);
    write_register(REG_MIN_LENGTH, min_len);
    write_register(REG_MAX_PAYLOAD, max_pay);
    settings_used++;
  endtask

  // A frame under the current headers with random body bytes.
  task automatic send_frame(input int len, input bit bad_sum);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    frames_sent++;
    send_item(reg_model.header_first);
    send_item(reg_model.header_second);
    send_item(8'(len));
    sum = 8'(len);
    for (int i = 0; i < len - 2; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      send_item(b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(sum);
  endtask

  // Header bytes followed by a length byte outside the bounds.
  task automatic send_bad_length(input logic [ByteW-1:0] len);
    send_item(reg_model.header_first);
    send_item(reg_model.header_second);
    send_item(len);
  endtask

  // Drops in hunt, bad second header, short and long lengths, good and bad sums.
  task automatic test_directed_defaults();
    logic [ByteW-1:0] seq [23] = '{8'h00, 8'hFF, 8'hAA, 8'hAA, 8'h55,
                                   8'hAA, 8'h55, 8'h01, 8'hAA, 8'h55, 8'h25,
                                   8'hAA, 8'h55, 8'h04, 8'h12, 8'h34, 8'h4A,
                                   8'hAA, 8'h55, 8'h04, 8'hFF, 8'hFF, 8'h03};
    foreach (seq[i]) send_item(seq[i]);
    drain_results();
  endtask

  // The sink holds off for a long stretch while the source keeps offering bytes.
  task automatic test_back_pressure();
    steady_source = 1'b1;
    sink_hold = 250;
    repeat (3) send_frame(20, 1'b0);
    steady_source = 1'b0;
    drain_results();
  endtask

  // The source stops between frames until every result has come back.
  task automatic test_source_pause();
    send_frame(6, 1'b0);
    drain_results();
    send_frame(5, 1'b1);
    drain_results();
    repeat (3) send_item(8'($urandom));
    send_frame(4, 1'b0);
    drain_results();
  endtask

  // Register extremes: minimum below two, single legal length, the 9-bit upper bound.
  task automatic test_register_limits();
    write_all_registers(8'h3C, 8'hC3, 8'd0, 8'd3);
    send_bad_length(8'd0);
    send_bad_length(8'd1);
    send_frame(2, 1'b0);
    send_frame(3, 1'b0);
    send_bad_length(8'd4);

    write_all_registers(8'h00, 8'hFF, 8'd10, 8'd0);
    send_frame(10, 1'b0);
    send_bad_length(8'd11);
    send_bad_length(8'd9);

    write_all_registers(8'hFF, 8'h00, RST_MIN_LENGTH, 8'd251);
    send_frame(255, 1'b1);
    send_frame(4, 1'b0);

    // Equal sync bytes, and a bound that only holds without wrap.
    write_all_registers(8'h7E, 8'h7E, 8'd255, 8'd251);
    send_frame(255, 1'b0);
    send_bad_length(8'd254);

    // A write past the last register must leave the settings alone.
    write_register(8'hFF, 8'h00);
    send_frame(255, 1'b0);
    drain_results();
  endtask

  // Random settings, each followed by mostly well-formed frames and some broken ones.
  task automatic test_random_traffic();
    int lo;
    int hi;
    int kind;
    int len;
    int phase_target;
    logic [ByteW-1:0] b;
    while (bytes_sent < RANDOM_BYTES) begin
      write_all_registers(8'($urandom),
                          ($urandom_range(0, 7) == 0) ? reg_model.header_first : 8'($urandom),
                          ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 255))
                                                      : 8'($urandom_range(2, 12)),
                          ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 251))
                                                      : 8'($urandom_range(0, 30)));
      if ($urandom_range(0, 3) == 0)
        write_register(8'($urandom_range(REG_MAX_PAYLOAD + 1, 255)), 8'($urandom));
      steady_source = ($urandom_range(0, 3) == 0);
      lo = (reg_model.min_frame_length < MIN_LEGAL_LENGTH) ? int'(MIN_LEGAL_LENGTH)
                                                           : int'(reg_model.min_frame_length);
      hi = int'(reg_model.min_frame_length) + int'(reg_model.max_payload_length);
      if (hi > 255) hi = 255;
      phase_target = bytes_sent + int'($urandom_range(80, 250));
      while (bytes_sent < phase_target) begin
        kind = int'($urandom_range(0, 99));
        if (kind < 80 && lo <= hi) begin
          if ($urandom_range(0, 29) == 0) len = int'($urandom_range(lo, hi));
          else len = lo + int'($urandom_range(0, (hi - lo < 10) ? hi - lo : 10));
          send_frame(len, kind >= 70);
        end else if (kind < 87) begin
          repeat ($urandom_range(1, 4)) send_item(8'($urandom));
        end else if (kind < 93) begin
          b = 8'($urandom);
          if (b == reg_model.header_second) b = ~b;
          send_item(reg_model.header_first);
          send_item(b);
        end else begin
          if (hi < 255 && $urandom_range(0, 1) == 1)
            send_bad_length(8'($urandom_range(hi + 1, 255)));
          else send_bad_length(8'($urandom_range(0, lo - 1)));
        end
      end
    end
    steady_source = 1'b0;
    drain_results();
  endtask

  // Sink stalls: a long hold-off when asked, otherwise a pattern that changes over time.
  always @(negedge clk) begin
    sink_cycle <= sink_cycle + 32'd1;
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      case (sink_cycle[8:7])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= 1'($urandom_range(0, 1));
        2'd2:    out_tready <= (sink_cycle[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      got_result.frame_byte    = out_tdata[ByteW-1:0];
      got_result.byte_position = out_tdata[2*ByteW-1:ByteW];
      got_result.frame_length  = out_tdata[3*ByteW-1:2*ByteW];
      got_result.is_last       = out_tlast;
      got_result.status        = out_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", int'(got_result.frame_byte), 0);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.frame_byte != want_result.frame_byte)
          report_mismatch("frame_byte", int'(got_result.frame_byte),
                          int'(want_result.frame_byte));
        if (got_result.byte_position != want_result.byte_position)
          report_mismatch("byte_position", int'(got_result.byte_position),
                          int'(want_result.byte_position));
        if (got_result.frame_length != want_result.frame_length)
          report_mismatch("frame_length", int'(got_result.frame_length),
                          int'(want_result.frame_length));
        if (got_result.is_last != want_result.is_last)
          report_mismatch("is_last", int'(got_result.is_last), int'(want_result.is_last));
        if (got_result.status != want_result.status)
          report_mismatch("status", int'(got_result.status), int'(want_result.status));
      end
    end
  end

  // Hard limit on the run time.
  initial begin
    #3000000;
    $display("Timed out with %0d results pending", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset once, then run the tests in turn.
  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_defaults();
    test_back_pressure();
    test_source_pause();
    test_register_limits();
    test_random_traffic();
    drain_results();

    $display("Sent %0d bytes (%0d dropped in hunt) in %0d frames over %0d register settings.",
             bytes_sent, bytes_dropped, frames_sent, settings_used);
    $display("Checked %0d results: %0d header, %0d length and %0d checksum errors predicted.",
             results_seen, header_errors, length_errors, sum_errors);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
